>>> hw/rtl/msdw_pkg.sv
// ---------------------------------------------------------------------------
// msdw_pkg: shared definitions for the multi-slot deadline watchdog
// Operation codes, field widths and default slot count.
// ---------------------------------------------------------------------------
package msdw_pkg;

    localparam int OP_W       = 2;
    localparam int SLOT_W     = 3;
    localparam int TIME_W     = 32;
    localparam int MASK_BITS  = 8;

    localparam int DEFAULT_SLOTS = 8;

    // Packed stream widths, rounded up to whole bytes
    localparam int IN_BITS    = OP_W + SLOT_W + TIME_W + TIME_W;
    localparam int S_DATA_W   = ((IN_BITS + 7) / 8) * 8;
    localparam int M_DATA_W   = ((2 * MASK_BITS + 7) / 8) * 8;

    localparam logic [OP_W-1:0] OP_REGISTER = 2'd0;
    localparam logic [OP_W-1:0] OP_KICK     = 2'd1;
    localparam logic [OP_W-1:0] OP_CHECK    = 2'd2;

endpackage

>>> hw/rtl/msdw_miss_unit.sv
// ---------------------------------------------------------------------------
// msdw_miss_unit: shared subtract-compare unit
// Computes elapsed time since the last kick, modulo 2^32, and flags a miss
// when it exceeds the deadline on a used, alive slot.
// ---------------------------------------------------------------------------
module msdw_miss_unit (
    input  logic [msdw_pkg::TIME_W-1:0] now_ms,
    input  logic [msdw_pkg::TIME_W-1:0] last_kick,
    input  logic [msdw_pkg::TIME_W-1:0] deadline,
    input  logic                        used,
    input  logic                        alive,
    output logic                        miss
);
    import msdw_pkg::*;

    logic [TIME_W-1:0] elapsed;

    assign elapsed = now_ms - last_kick;
    assign miss    = used && alive && (elapsed > deadline);

endmodule

>>> hw/rtl/multi_slot_deadline_watchdog.sv
// ---------------------------------------------------------------------------
// multi_slot_deadline_watchdog: table of software watchdog slots
// Register, kick and check operations over SLOTS deadline slots.
// ---------------------------------------------------------------------------
// Usage:
//   s_axis carries one operation per transaction: register a slot (store its
//   deadline, stamp now_ms, set alive), kick a slot (stamp now_ms, set alive)
//   or check all slots. Register and kick complete in the accepting cycle and
//   return nothing; a slot index not below SLOTS, or op code three, is
//   dropped.
//   A check walks the slots one per cycle through a single subtract-compare
//   unit, so it occupies the block from its acceptance through the walk and
//   until the result is loaded into the output register; s_axis_tready is
//   low meanwhile. The result (newly missed mask, alive mask) then sits on
//   m_axis until taken. If the receiver stalls, further register and kick
//   transactions are still accepted; a new check walks but holds its result
//   in the final step until the output register frees.
//   Reset clears all used, alive and last-kick state and empties the output.
// ---------------------------------------------------------------------------
module multi_slot_deadline_watchdog #(
    parameter int SLOTS = msdw_pkg::DEFAULT_SLOTS
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // tdata: op[1:0], slot[4:2], deadline[36:5], now_ms[68:37], zero fill
    input  logic [msdw_pkg::S_DATA_W-1:0] s_axis_tdata,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // tdata: newly_missed[7:0], alive_mask[15:8]
    output logic [msdw_pkg::M_DATA_W-1:0] m_axis_tdata,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready
);
    import msdw_pkg::*;

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_WALK  = 2'd1;
    localparam logic [1:0] ST_FLUSH = 2'd2;

    // Input field unpack
    logic [OP_W-1:0]   in_op;
    logic [SLOT_W-1:0] in_slot;
    logic [TIME_W-1:0] in_deadline;
    logic [TIME_W-1:0] in_now;

    assign in_op       = s_axis_tdata[OP_W-1:0];
    assign in_slot     = s_axis_tdata[OP_W+SLOT_W-1:OP_W];
    assign in_deadline = s_axis_tdata[OP_W+SLOT_W+TIME_W-1:OP_W+SLOT_W];
    assign in_now      = s_axis_tdata[OP_W+SLOT_W+2*TIME_W-1:OP_W+SLOT_W+TIME_W];

    // Slot table
    logic [SLOTS-1:0]  used_reg;
    logic [SLOTS-1:0]  alive_reg;
    logic [TIME_W-1:0] deadline_reg  [SLOTS];
    logic [TIME_W-1:0] last_kick_reg [SLOTS];

    // Sequencer
    logic [1:0]           state_reg, state_next;
    logic [IDX_W-1:0]     idx_reg, idx_next;
    logic [TIME_W-1:0]    now_reg;
    logic [MASK_BITS-1:0] missed_reg, missed_next;

    // Output register
    logic                 m_valid_reg;
    logic [M_DATA_W-1:0]  m_data_reg;

    logic in_fire;
    logic out_free;
    logic miss;
    logic clear_alive;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign out_free      = !m_valid_reg || m_axis_tready;

    msdw_miss_unit u_miss (
        .now_ms    (now_reg),
        .last_kick (last_kick_reg[idx_reg]),
        .deadline  (deadline_reg[idx_reg]),
        .used      (used_reg[idx_reg]),
        .alive     (alive_reg[idx_reg]),
        .miss      (miss)
    );

    assign clear_alive = (state_reg == ST_WALK) && miss;

    always_comb begin
        state_next  = state_reg;
        idx_next    = idx_reg;
        missed_next = missed_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_fire && in_op == OP_CHECK) begin
                    state_next  = ST_WALK;
                    idx_next    = '0;
                    missed_next = '0;
                end
            end
            ST_WALK: begin
                for (int j = 0; j < MASK_BITS; j++) begin
                    if (j < SLOTS && idx_reg == IDX_W'(j) && miss) begin
                        missed_next[j] = 1'b1;
                    end
                end
                if (idx_reg == LAST_IDX) begin
                    state_next = ST_FLUSH;
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_FLUSH: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            idx_reg    <= '0;
            missed_reg <= '0;
        end else begin
            state_reg  <= state_next;
            idx_reg    <= idx_next;
            missed_reg <= missed_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire && in_op == OP_CHECK) begin
            now_reg <= in_now;
        end
    end

    // Table update: register/kick writes in idle, alive clears while walking
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_reg  <= '0;
            alive_reg <= '0;
            for (int i = 0; i < SLOTS; i++) begin
                last_kick_reg[i] <= '0;
            end
        end else begin
            for (int i = 0; i < SLOTS; i++) begin
                if (in_fire && i < (1 << SLOT_W) && in_slot == SLOT_W'(i)
                        && (in_op == OP_REGISTER || in_op == OP_KICK)) begin
                    last_kick_reg[i] <= in_now;
                    alive_reg[i]     <= 1'b1;
                    if (in_op == OP_REGISTER) begin
                        used_reg[i] <= 1'b1;
                    end
                end
                if (clear_alive && idx_reg == IDX_W'(i)) begin
                    alive_reg[i] <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < SLOTS; i++) begin
            if (in_fire && in_op == OP_REGISTER && i < (1 << SLOT_W)
                    && in_slot == SLOT_W'(i)) begin
                deadline_reg[i] <= in_deadline;
            end
        end
    end

    // Output register
    logic [MASK_BITS-1:0] alive_out;

    always_comb begin
        alive_out = '0;
        for (int j = 0; j < MASK_BITS; j++) begin
            if (j < SLOTS) begin
                alive_out[j] = alive_reg[j];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (state_reg == ST_FLUSH && out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_FLUSH && out_free) begin
            m_data_reg <= M_DATA_W'({alive_out, missed_reg});
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

endmodule
